FILE: hw/rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the delta timer queue
// Holds the list size, the result status codes and the command word that
// passes from the front end to the execution engine.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int Timers = 16;
  localparam int PosW   = $clog2(Timers);
  localparam int CntW   = $clog2(Timers + 1);
  localparam int IdW    = 4;
  localparam int AmtW   = 32;

  localparam logic [1:0] OpInsert  = 2'd0;
  localparam logic [1:0] OpRemove  = 2'd1;
  localparam logic [1:0] OpAdvance = 2'd2;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_ACTIVE    = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_DONE      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_REMOVE,
    CMD_ADVANCE,
    CMD_BADID
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [IdW-1:0]    id;
    logic [AmtW-1:0]   amount;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_ADV
  } bk_state_t;

endpackage

FILE: hw/rtl/dtq_front.sv
// ----------------------------------------------------------------------------
// dtq_front: command front end
// Decode incoming words, drop unused opcodes, flag out-of-range ids and hold
// the words in a two-entry queue for the execution engine.
// ----------------------------------------------------------------------------
module dtq_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_op,
  input  logic [3:0]               in_timer_id,
  input  logic [31:0]              in_amount,
  output logic                     q_valid,
  output dtq_pkg::cmd_t            q_cmd,
  input  logic                     q_pop
);

  dtq_pkg::cmd_t q_mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    fill_r, fill_nxt;
  logic          push;
  dtq_pkg::cmd_t dec;

  assign busy    = (fill_r == 2'd2);
  assign q_valid = (fill_r != 2'd0);
  assign q_cmd   = q_mem_r[rd_ptr_r];

  always_comb begin
    dec.id     = in_timer_id;
    dec.amount = in_amount;
    dec.kind   = dtq_pkg::CMD_ADVANCE;
    push       = start && !busy;
    case (in_op)
      dtq_pkg::OpInsert: begin
        dec.kind = (32'(in_timer_id) >= dtq_pkg::Timers) ? dtq_pkg::CMD_BADID
                                                          : dtq_pkg::CMD_INSERT;
      end
      dtq_pkg::OpRemove: begin
        dec.kind = (32'(in_timer_id) >= dtq_pkg::Timers) ? dtq_pkg::CMD_BADID
                                                          : dtq_pkg::CMD_REMOVE;
      end
      dtq_pkg::OpAdvance: begin
        dec.kind = dtq_pkg::CMD_ADVANCE;
      end
      default: begin
        push = 1'b0;  // drop unused opcode
      end
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

FILE: hw/rtl/dtq_back.sv
// ----------------------------------------------------------------------------
// dtq_back: delta list execution engine
// Keep the ordered delta list and run insert, remove and advance on it,
// one list position per cycle, with at most one registered result per cycle.
// ----------------------------------------------------------------------------
module dtq_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  dtq_pkg::cmd_t         q_cmd,
  output logic                  q_pop,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [3:0]            out_expired_id,
  output logic [31:0]           out_overshoot,
  output logic                  out_last_item
);

  localparam int T  = dtq_pkg::Timers;
  localparam int PW = dtq_pkg::PosW;
  localparam int CW = dtq_pkg::CntW;

  dtq_pkg::bk_state_t state_r, state_nxt;

  logic [3:0]    ids_r   [T];
  logic [3:0]    ids_nxt [T];
  logic [31:0]   rel_r   [T];
  logic [31:0]   rel_nxt [T];
  logic          flags_r   [T];
  logic          flags_nxt [T];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   last_r, last_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [31:0]   cum_r, cum_nxt;
  logic [31:0]   prev_r, prev_nxt;
  logic [31:0]   amt_r, amt_nxt;
  logic [3:0]    id_r, id_nxt;

  logic          ov_r, ov_nxt;
  logic [2:0]    os_r, os_nxt;
  logic [3:0]    oid_r, oid_nxt;
  logic [31:0]   oov_r, oov_nxt;
  logic          ol_r, ol_nxt;

  logic [PW-1:0] q_idx;
  logic [PW-1:0] rm_pos;
  logic [31:0]   cum_sum;
  logic [31:0]   walk_rel;

  assign q_pop          = (state_r == dtq_pkg::BK_IDLE) && q_valid;
  assign out_valid      = ov_r;
  assign out_status     = os_r;
  assign out_expired_id = oid_r;
  assign out_overshoot  = oov_r;
  assign out_last_item  = ol_r;

  assign q_idx    = PW'(q_cmd.id);
  assign walk_rel = rel_r[pos_r[PW-1:0]];
  assign cum_sum  = cum_r + walk_rel;

  // ids in the list are unique, so at most one position matches
  always_comb begin
    rm_pos = '0;
    for (int i = 0; i < T; i++) begin
      if ((CW'(i) < cnt_r) && (ids_r[i] == q_cmd.id)) begin
        rm_pos = rm_pos | PW'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dtq_pkg::BK_IDLE: begin
        if (q_valid) begin
          if (q_cmd.kind == dtq_pkg::CMD_ADVANCE) begin
            state_nxt = dtq_pkg::BK_ADV;
          end else if (q_cmd.kind == dtq_pkg::CMD_INSERT && !flags_r[q_idx] &&
                       cnt_r < CW'(T) && cnt_r != '0 && q_cmd.amount < last_r) begin
            state_nxt = dtq_pkg::BK_WALK;
          end
        end
      end
      dtq_pkg::BK_WALK: begin
        if (pos_r == cnt_r || cum_sum >= amt_r) begin
          state_nxt = dtq_pkg::BK_IDLE;
        end
      end
      dtq_pkg::BK_ADV: begin
        if (!(cnt_r != '0 && amt_r >= rel_r[0])) begin
          state_nxt = dtq_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = dtq_pkg::BK_IDLE;
      end
    endcase
  end

  // datapath and result word
  always_comb begin
    ids_nxt   = ids_r;
    rel_nxt   = rel_r;
    flags_nxt = flags_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    pos_nxt   = pos_r;
    cum_nxt   = cum_r;
    prev_nxt  = prev_r;
    amt_nxt   = amt_r;
    id_nxt    = id_r;
    ov_nxt    = 1'b0;
    os_nxt    = dtq_pkg::ST_DONE;
    oid_nxt   = '0;
    oov_nxt   = '0;
    ol_nxt    = 1'b1;
    case (state_r)
      dtq_pkg::BK_IDLE: begin
        if (q_valid) begin
          oid_nxt = q_cmd.id;
          amt_nxt = q_cmd.amount;
          id_nxt  = q_cmd.id;
          pos_nxt = '0;
          cum_nxt = '0;
          prev_nxt = '0;
          case (q_cmd.kind)
            dtq_pkg::CMD_BADID: begin
              ov_nxt = 1'b1;
              os_nxt = dtq_pkg::ST_NOT_FOUND;
            end
            dtq_pkg::CMD_INSERT: begin
              if (flags_r[q_idx]) begin
                ov_nxt = 1'b1;
                os_nxt = dtq_pkg::ST_ACTIVE;
              end else if (cnt_r >= CW'(T)) begin
                flags_nxt[q_idx] = 1'b1;
                ov_nxt = 1'b1;
                os_nxt = dtq_pkg::ST_INSERTED;
              end else if (cnt_r == '0 || q_cmd.amount >= last_r) begin
                // append at the tail
                ids_nxt[cnt_r[PW-1:0]] = q_cmd.id;
                rel_nxt[cnt_r[PW-1:0]] = q_cmd.amount - last_r;
                last_nxt = q_cmd.amount;
                cnt_nxt  = cnt_r + 1'b1;
                flags_nxt[q_idx] = 1'b1;
                ov_nxt = 1'b1;
                os_nxt = dtq_pkg::ST_INSERTED;
              end
            end
            dtq_pkg::CMD_REMOVE: begin
              ov_nxt = 1'b1;
              if (!flags_r[q_idx]) begin
                os_nxt = dtq_pkg::ST_NOT_FOUND;
              end else begin
                os_nxt = dtq_pkg::ST_REMOVED;
                flags_nxt[q_idx] = 1'b0;
                cnt_nxt = cnt_r - 1'b1;
                if (CW'(rm_pos) + 1'b1 < cnt_r) begin
                  for (int i = 0; i < T - 1; i++) begin
                    if (PW'(i) > rm_pos) begin
                      ids_nxt[i] = ids_r[i+1];
                      rel_nxt[i] = rel_r[i+1];
                    end else if (PW'(i) == rm_pos) begin
                      ids_nxt[i] = ids_r[i+1];
                      rel_nxt[i] = rel_r[i+1] + rel_r[i];
                    end
                  end
                end else begin
                  last_nxt = last_r - rel_r[rm_pos];
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      dtq_pkg::BK_WALK: begin
        oid_nxt = id_r;
        os_nxt  = dtq_pkg::ST_INSERTED;
        if (pos_r == cnt_r) begin
          ids_nxt[cnt_r[PW-1:0]] = id_r;
          rel_nxt[cnt_r[PW-1:0]] = amt_r - cum_r;
          last_nxt = last_r + (amt_r - cum_r);
          cnt_nxt  = cnt_r + 1'b1;
          flags_nxt[PW'(id_r)] = 1'b1;
          ov_nxt = 1'b1;
        end else if (cum_sum >= amt_r) begin
          // open a slot at the walk position, shift the tail up
          for (int i = 1; i < T; i++) begin
            if (CW'(i) > pos_r) begin
              ids_nxt[i] = ids_r[i-1];
              rel_nxt[i] = rel_r[i-1];
            end
            if (CW'(i) == pos_r + 1'b1) begin
              rel_nxt[i] = cum_sum - amt_r;
            end
          end
          ids_nxt[pos_r[PW-1:0]] = id_r;
          rel_nxt[pos_r[PW-1:0]] = amt_r - prev_r;
          cnt_nxt = cnt_r + 1'b1;
          flags_nxt[PW'(id_r)] = 1'b1;
          ov_nxt = 1'b1;
        end else begin
          cum_nxt  = cum_sum;
          prev_nxt = cum_sum;
          pos_nxt  = pos_r + 1'b1;
        end
      end
      dtq_pkg::BK_ADV: begin
        ov_nxt = 1'b1;
        if (cnt_r != '0 && amt_r >= rel_r[0]) begin
          amt_nxt  = amt_r - rel_r[0];
          last_nxt = last_r - rel_r[0];
          os_nxt   = dtq_pkg::ST_EXPIRED;
          oid_nxt  = ids_r[0];
          oov_nxt  = amt_r - rel_r[0];
          ol_nxt   = 1'b0;
          if (32'(ids_r[0]) < T) begin
            flags_nxt[PW'(ids_r[0])] = 1'b0;
          end
          for (int i = 0; i < T - 1; i++) begin
            ids_nxt[i] = ids_r[i+1];
            rel_nxt[i] = rel_r[i+1];
          end
          cnt_nxt = cnt_r - 1'b1;
        end else if (cnt_r != '0) begin
          rel_nxt[0] = rel_r[0] - amt_r;
          last_nxt   = last_r - amt_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtq_pkg::BK_IDLE;
      cnt_r   <= '0;
      last_r  <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < T; i++) begin
        flags_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      ov_r    <= ov_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ids_r  <= ids_nxt;
    rel_r  <= rel_nxt;
    pos_r  <= pos_nxt;
    cum_r  <= cum_nxt;
    prev_r <= prev_nxt;
    amt_r  <= amt_nxt;
    id_r   <= id_nxt;
    os_r   <= os_nxt;
    oid_r  <= oid_nxt;
    oov_r  <= oov_nxt;
    ol_r   <= ol_nxt;
  end

endmodule

FILE: hw/rtl/delta_timer_queue.sv
// ----------------------------------------------------------------------------
// delta_timer_queue: ordered delta-list queue of software timers
// Insert, remove and advance on up to dtq_pkg::Timers timers.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a command word by raising start with in_op, in_timer_id and
//   in_amount; it is taken at a rising edge with start high and busy low.
//   A front end decodes the word into a two-entry queue, so busy only rises
//   while two words wait behind a running command.
//   Results come out one per cycle, each marked by out_valid for a single
//   cycle; out_last_item flags the final result of a command. The receiver
//   has no way to stall, so every result must be taken as it appears.
//   Remove, rejected commands and tail inserts give their result from the
//   idle state; an insert inside the list first walks one list position
//   per cycle. Advance gives one expiry per cycle, then the done word.
//   An advance that expires every timer is the longest command. Opcode 3
//   is dropped with no result. Reset clears the list, all active flags and
//   the queue; no sweep is run.
// ----------------------------------------------------------------------------
module delta_timer_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_timer_id,
  input  logic [31:0] in_amount,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [3:0]  out_expired_id,
  output logic [31:0] out_overshoot,
  output logic        out_last_item
);

  logic          q_valid;
  logic          q_pop;
  dtq_pkg::cmd_t q_cmd;

  // front: accept and classify words, buffer them
  dtq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_op       (in_op),
    .in_timer_id (in_timer_id),
    .in_amount   (in_amount),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop)
  );

  // back: run each command on the delta list
  dtq_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_expired_id (out_expired_id),
    .out_overshoot  (out_overshoot),
    .out_last_item  (out_last_item)
  );

  // only expiry words leave a command open
  a_last_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_item |-> out_status == dtq_pkg::ST_EXPIRED)
    else $error("non-final result is not an expiry");

  // overshoot is zero on everything but expiry
  a_overshoot : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dtq_pkg::ST_EXPIRED |-> out_overshoot == 32'd0)
    else $error("overshoot set on non-expiry result");

  // no result right after reset
  a_reset_quiet : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule
